// ----- sv/assert_macros.svh -----
// Assertion macros shared by the line assembler RTL.
// Self-contained; bodies are compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- sv/tla_pkg.sv -----
// Types and constants of the terminal line assembler.
// No dependencies; used by the controller, the top level and the testbench.
package tla_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] line_char;
    logic       last;
  } res_item_t;

  // Result kinds.
  localparam logic KIND_LINE_CHAR = 1'b0;
  localparam logic KIND_TOO_LONG  = 1'b1;

  // Terminal byte codes.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_NOTICE
  } tla_state_e;

  // Request from the controller to load the output register.
  typedef struct packed {
    logic load;
    logic kind;
    logic from_ram;
    logic last;
  } res_load_t;

endpackage

// ----- sv/tla_stream_if.sv -----
// Valid/ready stream interface used for both channels of the line assembler.
// Depends on nothing; the payload type is set by the instantiating level.
interface tla_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/tla_ram.sv -----
// Generic single-port synchronous RAM with a registered, enabled read.
// No dependencies.
module tla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tla_ctrl.sv -----
// Line controller: byte decoding, line length and overflow tracking, read-out sequencing.
// Depends on tla_pkg and assert_macros.svh; drives the line RAM and the output register.
`include "assert_macros.svh"
module tla_ctrl
  import tla_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [7:0]                       in_byte_i,
  output logic                             in_ready_o,
  input  logic                             out_free_i,
  output res_load_t                        load_o,
  output logic                             ram_we_o,
  output logic                             ram_re_o,
  output logic [$clog2(LINE_CAPACITY)-1:0] ram_addr_o,
  output logic [7:0]                       ram_wdata_o
);

  localparam int LW = $clog2(LINE_CAPACITY);
  localparam logic [LW-1:0] LenMax = LW'(LINE_CAPACITY - 1);

  tla_state_e    state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] idx_q, idx_d;
  logic          ovf_q, ovf_d;
  logic          is_last;

  assign is_last = (idx_q == LW'(len_q - LW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    in_ready_o  = 1'b0;
    load_o      = '0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = len_q;
    ram_wdata_o = (in_byte_i == CHAR_TAB) ? CHAR_SPACE : in_byte_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          priority if (in_byte_i == CHAR_CR || in_byte_i == CHAR_LF) begin
            ovf_d = 1'b0;
            if (ovf_q) begin
              len_d   = '0;
              state_d = ST_NOTICE;
            end else if (len_q != '0) begin
              // Start read-out at the first stored byte.
              idx_d      = '0;
              ram_re_o   = 1'b1;
              ram_addr_o = '0;
              state_d    = ST_LOAD;
            end
          end else if (in_byte_i == CHAR_BS || in_byte_i == CHAR_DEL) begin
            if (!ovf_q && len_q != '0) begin
              len_d = len_q - LW'(1);
            end
          end else if (ovf_q) begin
            // Discard until the terminator.
          end else if (in_byte_i < CHAR_SPACE && in_byte_i != CHAR_TAB) begin
            // Other control bytes are dropped.
          end else if (len_q == LenMax) begin
            ovf_d = 1'b1;
          end else begin
            ram_we_o = 1'b1;
            len_d    = len_q + LW'(1);
          end
        end
      end

      ST_LOAD: begin
        if (out_free_i) begin
          load_o.load     = 1'b1;
          load_o.kind     = KIND_LINE_CHAR;
          load_o.from_ram = 1'b1;
          load_o.last     = is_last;
          if (is_last) begin
            len_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d      = idx_q + LW'(1);
            ram_re_o   = 1'b1;
            ram_addr_o = idx_q + LW'(1);
          end
        end
      end

      ST_NOTICE: begin
        if (out_free_i) begin
          load_o.load = 1'b1;
          load_o.kind = KIND_TOO_LONG;
          load_o.last = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLY(a_no_rw_clash, clk_i, rst_ni, ram_we_o, !ram_re_o)
  `ASSERT_IMPLY(a_len_in_range, clk_i, rst_ni, 1'b1, len_q <= LenMax)
  `ASSERT_IMPLY(a_ovf_only_full, clk_i, rst_ni, ovf_q, len_q == LenMax)
  `ASSERT_NEXT(a_last_clears_line, clk_i, rst_ni, load_o.load && load_o.last,
               len_q == '0 && state_q == ST_IDLE)

endmodule

// ----- sv/terminal_line_assembler.sv -----
// Top level of the terminal line assembler: controller, line RAM and output register.
// Depends on tla_pkg, tla_stream_if, tla_ram and tla_ctrl.
//
// Use: received terminal bytes arrive one per transfer on rx_i; results leave on res_o,
// each carrying kind, line_char and last. Printable and high bytes are kept in a line RAM,
// tab is kept as a space, BS and DEL erase the last byte and other control bytes
// vanish. A line longer than LINE_CAPACITY minus one bytes is marked overflowed.
// CR or LF ends the line: an overflowed line yields one too-long notice, a non-empty
// line yields its bytes with last on the final one, and an empty line yields nothing.
// Throughput: one input transfer per cycle for every byte except a terminator. A
// terminator that produces output holds rx_i not ready until its last result has been
// loaded into the output register: the line RAM's single port reads one byte a cycle,
// and read-out advances only while the output register is free.
// The RAM read of the first byte of a line is issued at the terminator transfer, and
// the output register takes the registered read data once the register is free.
// When the receiver stalls, the output register holds its result and read-out pauses;
// ordinary bytes are still accepted while a final result waits to be taken.
// Reset clears the line length, the overflow flag and the output valid; the RAM
// contents are not cleared and need no clearing pass.
module terminal_line_assembler
  import tla_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tla_stream_if.sink   rx_i,
  tla_stream_if.source res_o
);

  localparam int AW = $clog2(LINE_CAPACITY);

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  res_load_t     load;
  logic          out_free;

  // Output register state.
  logic      res_valid_q;
  res_item_t res_q;

  // The output register can take a new result when empty or being drained this cycle.
  assign out_free = !res_valid_q || res_o.ready;

  tla_ctrl #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_byte_i   (rx_i.data.rx_byte),
    .in_ready_o  (rx_i.ready),
    .out_free_i  (out_free),
    .load_o      (load),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata)
  );

  // Line store: one entry per stored byte; reads and writes never share a cycle,
  // since writes happen only for stored bytes and reads only at a terminator or during read-out.
  tla_ram #(
    .WIDTH(8),
    .DEPTH(LINE_CAPACITY)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load.load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; it is qualified by res_valid_q.
  always_ff @(posedge clk_i) begin
    if (load.load) begin
      res_q.kind      <= load.kind;
      res_q.line_char <= load.from_ram ? ram_rdata : 8'h00;
      res_q.last      <= load.last;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the terminal line assembler.
// Depends on tla_pkg, tla_stream_if and terminal_line_assembler from the RTL.
module testbench;
  import tla_pkg::*;

  // The block is built at its full line capacity, so a line holds up to 63 bytes.
  localparam int LINE_CAP       = 64;
  // Allowance for the first result of a line to reach the output after the terminator transfer.
  localparam int LINE_LATENCY   = 1;
  // Guard against a hung run; the slowest correct run is well below this.
  localparam int CYCLE_LIMIT    = 1000000;
  // Least number of input items sent in each idling phase; the last line may run past it.
  localparam int ITEMS_PER_MODE = 35;

  logic clk_i;
  logic rst_ni;

  tla_stream_if #(.payload_t(in_item_t))  rx_if ();
  tla_stream_if #(.payload_t(res_item_t)) res_if ();

  terminal_line_assembler #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  // Predicted line state, kept apart from the block and updated on every accepted byte.
  logic [7:0] line_mem [LINE_CAP];
  int         line_len;
  logic       line_overflowed;

  // Results that the predicted line state says must still leave the block, oldest first.
  res_item_t  pending_results [$];

  int mismatch_count;
  int items_sent;
  int cycle_count;

  // Idling controls, in percent; set at start-up and then written by the test tasks only.
  int send_idle_pct;
  int recv_stall_pct;

  // A long receiver hold-off is requested by bumping hold_req; the receiver process
  // acknowledges it and counts the stalled cycles itself.
  int hold_req;
  int hold_ack;
  int hold_len;
  int hold_left;

  // The clock toggles every 10 time units, giving a period of 20.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Cycle counter and timeout. Should the run hang, it ends here with a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver side. Ready changes only at the falling edge; a pending hold-off request
  // keeps it low for the requested number of cycles, otherwise it stalls at random.
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Works out what one accepted byte does to the line, and queues the results that a
  // terminator releases.
  function automatic void predict_line(input logic [7:0] rx_byte);
    if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
      if (line_overflowed) begin
        pending_results.push_back(res_item_t'{kind: KIND_TOO_LONG, line_char: 8'h00,
                                              last: 1'b1});
      end else begin
        for (int i = 0; i < line_len; i++) begin
          pending_results.push_back(res_item_t'{kind: KIND_LINE_CHAR,
                                                line_char: line_mem[i],
                                                last: (i == line_len - 1)});
        end
      end
      line_len        = 0;
      line_overflowed = 1'b0;
    end else if (rx_byte == CHAR_BS || rx_byte == CHAR_DEL) begin
      // Erasing is ignored on an empty line and once the line has overflowed.
      if (!line_overflowed && line_len > 0) begin
        line_len--;
      end
    end else if (line_overflowed) begin
      // Everything up to the terminator is discarded.
    end else if (rx_byte < CHAR_SPACE && rx_byte != CHAR_TAB) begin
      // Remaining control bytes vanish without effect.
    end else if (line_len + 1 >= LINE_CAP) begin
      line_overflowed = 1'b1;
    end else begin
      line_mem[line_len] = (rx_byte == CHAR_TAB) ? CHAR_SPACE : rx_byte;
      line_len++;
    end
  endfunction

  // Observer. At each rising edge the accepted input byte, if any, is predicted first,
  // and then the accepted result, if any, is compared with the oldest expectation.
  always @(posedge clk_i) begin
    res_item_t want;
    res_item_t got;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        predict_line(rx_if.data.rx_byte);
      end
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("testbench: unexpected result kind %0d char %02h last %0d",
                     got.kind, got.line_char, got.last);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.line_char !== want.line_char ||
              got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("testbench: mismatch: expected kind %0d char %02h last %0d,",
                       want.kind, want.line_char, want.last,
                       " got kind %0d char %02h last %0d",
                       got.kind, got.line_char, got.last);
            end
          end
        end
      end
    end
  end

  // Offers one byte and returns at the falling edge after its transfer. Valid is written
  // at most once per falling edge, so back-to-back bytes keep it high throughout.
  task automatic send_byte(input logic [7:0] rx_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.data  <= in_item_t'{rx_byte: rx_byte};
    do @(posedge clk_i); while (!rx_if.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Stops offering and waits until every expected result has been taken, then lets the
  // block's latency pass so that nothing is still in flight.
  task automatic wait_for_drain();
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (LINE_LATENCY + 3) @(negedge clk_i);
  endtask

  // A byte that may appear inside a line: mostly printable, with tabs, erasures, high
  // bytes and stray control bytes mixed in, but never a terminator.
  function automatic logic [7:0] pick_line_byte();
    int         sel;
    logic [7:0] pick;
    sel = $urandom_range(99);
    if (sel < 60) begin
      pick = 8'($urandom_range(8'h7E, 8'h20));
    end else if (sel < 72) begin
      pick = 8'($urandom_range(8'hFF, 8'h80));
    end else if (sel < 80) begin
      pick = CHAR_TAB;
    end else if (sel < 90) begin
      pick = $urandom_range(1) ? CHAR_BS : CHAR_DEL;
    end else begin
      pick = 8'($urandom_range(8'h1F, 8'h00));
      if (pick == CHAR_CR || pick == CHAR_LF) begin
        pick = 8'h00;
      end
    end
    return pick;
  endfunction

  // Sends one line of random content with a terminator, sometimes followed by an extra LF.
  task automatic send_random_line();
    int n;
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(70, 55);
    end else begin
      n = $urandom_range(12, 0);
    end
    for (int i = 0; i < n; i++) begin
      send_byte(pick_line_byte());
    end
    send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
    if ($urandom_range(99) < 15) begin
      send_byte(CHAR_LF);
    end
  endtask

  // Control bytes, erasure on an empty line, tab, the extremes of the byte range and
  // the CR LF pair that ends an empty line.
  task automatic test_special_bytes();
    logic [7:0] seq [] = '{CHAR_CR, 8'h00, 8'h1F, 8'h01, CHAR_BS, CHAR_DEL,
                           CHAR_SPACE, CHAR_TAB, 8'h7E, 8'h80, 8'hFF, 8'h21,
                           CHAR_BS, CHAR_DEL, 8'h41, CHAR_CR, 8'h78, CHAR_CR,
                           CHAR_LF, CHAR_LF, 8'h1B, 8'h31, CHAR_LF};
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
    wait_for_drain();
  endtask

  // A line filled to capacity, a line that overflows and so ignores erasure, and a
  // line brought back under the limit by erasing before it fills.
  task automatic test_line_full();
    for (int i = 0; i < LINE_CAP - 1; i++) begin
      send_byte(8'($urandom_range(8'h7E, 8'h20)));
    end
    send_byte(CHAR_CR);
    for (int i = 0; i < LINE_CAP; i++) begin
      send_byte(8'($urandom_range(8'hFF, 8'h80)));
    end
    send_byte(CHAR_BS);
    send_byte(8'h41);
    send_byte(CHAR_LF);
    for (int i = 0; i < LINE_CAP - 2; i++) begin
      send_byte(8'($urandom_range(8'h7E, 8'h20)));
    end
    send_byte(CHAR_DEL);
    send_byte(CHAR_TAB);
    send_byte(8'h5A);
    send_byte(CHAR_CR);
    wait_for_drain();
  endtask

  // One idling mode of random traffic: mostly well-formed lines, the rest raw bytes
  // from the whole range, terminators included.
  task automatic test_random_lines(input int idle_pct, input int stall_pct);
    int stop_at;
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = items_sent + ITEMS_PER_MODE;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(255)));
        end
      end else begin
        send_random_line();
      end
    end
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while lines keep arriving, so the output
  // register fills and the block stops taking bytes until the hold-off ends.
  task automatic test_receiver_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 300;
    hold_req++;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 8; i++) begin
        send_byte(8'($urandom_range(8'h7E, 8'h20)));
      end
      send_byte(r[0] ? CHAR_LF : CHAR_CR);
    end
    wait_for_drain();
  endtask

  // The sender pauses after each line until every expected result has arrived.
  task automatic test_sender_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    for (int r = 0; r < 3; r++) begin
      send_random_line();
      wait_for_drain();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    rx_if.valid     = 1'b0;
    rx_if.data      = '0;
    res_if.ready    = 1'b0;
    line_len        = 0;
    line_overflowed = 1'b0;
    mismatch_count  = 0;
    items_sent      = 0;
    cycle_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 0;
    hold_ack        = 0;
    hold_len        = 0;
    hold_left       = 0;

    // Reset is held from time zero and released at a falling edge, once only.
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_special_bytes();
    test_line_full();
    test_random_lines(0, 0);
    test_random_lines(84, 0);
    test_random_lines(0, 84);
    test_random_lines(24, 24);
    test_receiver_hold_off();
    test_sender_pause();

    // Any result still expected at this point was never delivered.
    wait_for_drain();
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/tla_pkg.sv
sv/tla_stream_if.sv
sv/tla_ram.sv
sv/tla_ctrl.sv
sv/terminal_line_assembler.sv
bench/testbench.sv
